>>> rtl/pms_pkg.sv
package pms_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned NCH    = 4;
    localparam int unsigned PROD_W = 16;
    localparam int unsigned DEN_W  = 16;
    localparam int unsigned REM_W  = 24;
    localparam int unsigned QUO_W  = 9;

    localparam logic [CH_W-1:0]   CH_MAX       = 8'd255;
    localparam logic [DEN_W-1:0]  FULL_SQ      = 16'd65025;
    localparam logic [PROD_W-1:0] OPAQUE_LIMIT = 16'd64959;
    localparam logic [DEN_W-1:0]  MIN_DEN      = FULL_SQ - OPAQUE_LIMIT;

    // How the result of one pixel is formed.
    typedef enum logic [3:0] {
        MODE_PASS   = 4'b0001,
        MODE_CLEAR  = 4'b0010,
        MODE_SPLIT  = 4'b0100,
        MODE_OPAQUE = 4'b1000
    } t_mode;

    // Payload carried through the divider stages. In the pass and clear modes
    // the lift slot holds the source pixel.
    typedef struct packed {
        t_mode                            mode;
        logic [NCH-1:0][CH_W-1:0]         lift;
        logic [DEN_W-1:0]                 den;
        logic [NCH-1:0][REM_W-1:0]        rem;
        logic [NCH-1:0][QUO_W-1:0]        quo;
    } t_div_bus;

    // Exact floor(p / 255) for any product of two 8-bit values.
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + {9'd0, p[PROD_W-1:CH_W]} + 17'd1;
        return s[PROD_W-1:CH_W];
    endfunction

endpackage

>>> rtl/pms_div_stage.sv
module pms_div_stage
    import pms_pkg::*;
#(
    parameter int unsigned BIT = 0
) (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);

    t_div_bus r_bus;
    t_div_bus n_bus;

    // One restoring quotient bit for all four channels against a shared divisor.
    always_comb begin
        logic [REM_W:0] shifted;
        logic [REM_W:0] diff;
        n_bus   = i_bus;
        shifted = (REM_W + 1)'(i_bus.den) << BIT;
        for (int ch = 0; ch < NCH; ch++) begin
            diff = {1'b0, i_bus.rem[ch]} - shifted;
            if ({1'b0, i_bus.rem[ch]} >= shifted) begin
                n_bus.rem[ch]      = diff[REM_W-1:0];
                n_bus.quo[ch][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

>>> rtl/premultiplied_mask_split_core.sv
// Throughput: one item per cycle while m_axis_tready does not hold the output;
// the nine divider stages each resolve one quotient bit.
// Each stage holds its item only when the next one is full, so the input is
// still taken while a result waits, until all twelve stages are occupied.
// Reset (synchronous, active low) clears the stage valid bits and the selection
// register; the data registers are not reset.
module premultiplied_mask_split_core
    import pms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, mask_alpha
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lift_red, lift_green, lift_blue, lift_alpha,
    // rest_red, rest_green, rest_blue, rest_alpha
    output logic [63:0] m_axis_tdata
);

    localparam int unsigned NST = QUO_W + 3;

    logic           r_sel;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    // Stage A: products.
    logic [NCH-1:0][CH_W-1:0]   r_a_px;
    logic [NCH-1:0][PROD_W-1:0] r_a_cm;
    logic [NCH-1:0][PROD_W-1:0] r_a_cinv;
    logic [PROD_W-1:0]          r_a_am;
    t_mode                      r_a_mode;

    logic [NCH-1:0][CH_W-1:0] in_px;
    logic [CH_W-1:0]          in_m;
    t_mode                    n_a_mode;

    t_div_bus r_b;
    t_div_bus n_b;
    t_div_bus div_in  [QUO_W];
    t_div_bus div_out [QUO_W];

    logic [63:0] r_out;
    logic [63:0] n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (i_cfg_we) begin
            r_sel <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or its item moves on.
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            in_px[i] = s_axis_tdata[i*CH_W +: CH_W];
        end
        in_m = s_axis_tdata[NCH*CH_W +: CH_W];
        if (!r_sel) begin
            n_a_mode = MODE_PASS;
        end else if (in_m == '0) begin
            n_a_mode = MODE_CLEAR;
        end else begin
            n_a_mode = MODE_SPLIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < NCH; i++) begin
                r_a_px[i]   <= in_px[i];
                r_a_cm[i]   <= PROD_W'(in_px[i]) * PROD_W'(in_m);
                r_a_cinv[i] <= PROD_W'(in_px[i]) * PROD_W'(CH_MAX - in_m);
            end
            r_a_am   <= PROD_W'(in_px[NCH-1]) * PROD_W'(in_m);
            r_a_mode <= n_a_mode;
        end
    end

    // Stage B: lifted channels, divisor and dividends.
    always_comb begin
        n_b      = '0;
        n_b.mode = r_a_mode;
        n_b.den  = FULL_SQ - r_a_am;
        for (int i = 0; i < NCH; i++) begin
            n_b.rem[i] = (REM_W'(r_a_cinv[i]) << CH_W) - REM_W'(r_a_cinv[i]);
        end
        case (r_a_mode)
            MODE_SPLIT: begin
                for (int i = 0; i < NCH; i++) begin
                    n_b.lift[i] = div255(r_a_cm[i]);
                end
                if (r_a_am > OPAQUE_LIMIT) begin
                    n_b.mode = MODE_OPAQUE;
                end
            end
            default: begin
                n_b.lift = r_a_px;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b <= n_b;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        if (j == 0) begin : g_first
            assign div_in[j] = r_b;
        end else begin : g_next
            assign div_in[j] = div_out[j-1];
        end
        pms_div_stage #(
            .BIT (QUO_W - 1 - j)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en[2+j]),
            .i_bus (div_in[j]),
            .o_bus (div_out[j])
        );
    end

    // Output stage: saturate the quotients and lay out the result item.
    always_comb begin
        t_div_bus                 d;
        logic [NCH-1:0][CH_W-1:0] sat;
        d = div_out[QUO_W-1];
        for (int i = 0; i < NCH; i++) begin
            sat[i] = d.quo[i][QUO_W-1] ? CH_MAX : d.quo[i][CH_W-1:0];
        end
        case (d.mode)
            MODE_PASS: begin
                n_out = {32'd0, d.lift};
            end
            MODE_CLEAR: begin
                n_out = {d.lift, 32'd0};
            end
            MODE_SPLIT: begin
                n_out = {sat, d.lift};
            end
            default: begin
                n_out = {32'd0, d.lift};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = r_out;

    // The input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input refused with an empty stage");

    // A split item that reaches the divider has a divisor large enough.
    a_split_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_b.mode == MODE_SPLIT) |-> (r_b.den >= MIN_DEN))
        else $error("split item with near-zero divisor");

    // The opaque case is taken only when the divisor would be tiny.
    a_opaque_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_b.mode == MODE_OPAQUE) |-> (r_b.den < MIN_DEN))
        else $error("opaque item with usable divisor");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import pms_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned BLOCK_ITEMS  = 280;
    localparam int unsigned MAX_REPORTS  = 10;

    // Predicts the lifted and background pixels of every accepted item and
    // checks the results against them in order.
    class pixel_split_board;
        bit              sel_on;
        logic [63:0]     expected_splits[$];
        int unsigned     mismatches;
        int unsigned     n_sel_off;
        int unsigned     n_mask_zero;
        int unsigned     n_split;
        int unsigned     n_opaque;

        function new();
            sel_on      = 1'b0;
            mismatches  = 0;
            n_sel_off   = 0;
            n_mask_zero = 0;
            n_split     = 0;
            n_opaque    = 0;
        endfunction

        function automatic logic [63:0] predict_split(logic [39:0] px);
            int unsigned c;
            int unsigned m;
            int unsigned am;
            int unsigned den;
            int unsigned q;
            logic [63:0] r;
            m = {24'd0, px[39:32]};
            am = int'(px[31:24]) * m;
            r = '0;
            if (!sel_on) begin
                r[31:0] = px[31:0];
                n_sel_off++;
            end else if (m == 0) begin
                r[63:32] = px[31:0];
                n_mask_zero++;
            end else begin
                if (am <= 64959) n_split++;
                else n_opaque++;
                for (int i = 0; i < 4; i++) begin
                    c = {24'd0, px[8*i +: 8]};
                    r[8*i +: 8] = 8'((c * m) / 255);
                    if (am <= 64959) begin
                        den = 65025 - am;
                        q = (c * (255 - m) * 255) / den;
                        r[32 + 8*i +: 8] = (q > 255) ? 8'd255 : 8'(q);
                    end
                end
            end
            return r;
        endfunction

        function void note_pixel(logic [39:0] px);
            expected_splits.push_back(predict_split(px));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_split(logic [63:0] got);
            logic [63:0] want;
            string       names[8];
            names = '{"lift_red", "lift_green", "lift_blue", "lift_alpha",
                      "rest_red", "rest_green", "rest_blue", "rest_alpha"};
            if (expected_splits.size() == 0) begin
                report($sformatf("result item with nothing expected: %h", got));
                return;
            end
            want = expected_splits.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (got[8*i +: 8] !== want[8*i +: 8])
                    report($sformatf("%s: expected %0d, got %0d", names[i],
                                     want[8*i +: 8], got[8*i +: 8]));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned quiet_cycles;

    pixel_split_board board;

    premultiplied_mask_split_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) board.note_pixel(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_split(m_axis_tdata);
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [39:0] make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] a, logic [7:0] m);
        return {m, a, b, g, r};
    endfunction

    // Partly well-formed premultiplied pixels, with mask and alpha extremes
    // and near-opaque products weighted up.
    function automatic logic [39:0] random_pixel();
        logic [39:0] px;
        int unsigned a;
        px = 40'({$urandom, $urandom});
        case ($urandom_range(9))
            0: px[39:32] = 8'd0;
            1: px[39:32] = 8'd255;
            2: px[31:24] = 8'd255;
            3: begin
                px[31:24] = 8'($urandom_range(255, 240));
                px[39:32] = 8'($urandom_range(255, 240));
            end
            4, 5, 6: begin
                a = $urandom_range(255);
                px[31:24] = 8'(a);
                for (int i = 0; i < 3; i++) px[8*i +: 8] = 8'($urandom_range(a));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(logic [39:0] px);
        while (tx_idle_on && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (board.expected_splits.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_selection(bit v);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.sel_on = v;
    endtask

    initial begin
        logic [39:0] directed[$];
        bit          block_sel[6];

        board         = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        quiet_cycles  = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The selection register comes out of reset cleared: whole pixels lift.
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'h96));
        send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd78, 8'd0));

        set_selection(1'b1);
        directed = '{
            make_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0),
            make_pixel(8'd200, 8'd100, 8'd50,  8'd255, 8'd0),
            make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255),
            make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd254),
            make_pixel(8'd254, 8'd254, 8'd254, 8'd254, 8'd255),
            make_pixel(8'd255, 8'd128, 8'd1,   8'd254, 8'd255),
            make_pixel(8'd10,  8'd20,  8'd30,  8'd40,  8'd1),
            make_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd1),
            make_pixel(8'd255, 8'd0,   8'd255, 8'd0,   8'd128),
            make_pixel(8'd128, 8'd64,  8'd32,  8'd200, 8'd128),
            make_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd255),
            make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd1),
            make_pixel(8'h01,  8'h02,  8'h04,  8'h08,  8'h10),
            make_pixel(8'h20,  8'h40,  8'h80,  8'hFE,  8'hFD),
            make_pixel(8'd250, 8'd240, 8'd230, 8'd255, 8'd250),
            make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd240),
            make_pixel(8'd100, 8'd200, 8'd255, 8'd50,  8'd127)
        };
        foreach (directed[i]) send_pixel(directed[i]);

        block_sel = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        foreach (block_sel[k]) begin
            set_selection(block_sel[k]);
            // One block runs with both sides always ready.
            tx_idle_on = (k != 2);
            rx_idle_on = (k != 2);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if (n == BLOCK_ITEMS / 2 && k == 3) wait_for_results();
                send_pixel(random_pixel());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.expected_splits.size() != 0)
            board.report($sformatf("%0d results never arrived",
                                   board.expected_splits.size()));

        $display("Covered %0d pixels with selection off, %0d with a zero mask,",
                 board.n_sel_off, board.n_mask_zero);
        $display("%0d split normally and %0d with a near-opaque alpha product.",
                 board.n_split, board.n_opaque);
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/pms_pkg.sv
rtl/pms_div_stage.sv
rtl/premultiplied_mask_split_core.sv
dv/tb_top.sv
